[rtl/core/pnguf_pkg.sv]
// ----------------------------------------------------------------------------
// pnguf_pkg
// Shared types, limits and the Paeth predictor for the PNG scanline unfilter.
// ----------------------------------------------------------------------------
package pnguf_pkg;

	localparam int MAX_ROW_BYTES   = 8192;
	localparam int MAX_PIXEL_BYTES = 4;

	localparam int ADDR_W = $clog2(MAX_ROW_BYTES);
	localparam int COL_W  = $clog2(MAX_ROW_BYTES + 1);
	localparam int SEL_W  = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

	// field and register widths
	localparam int BYTE_W     = 8;
	localparam int PB_W       = 3;
	localparam int RB_W       = 14;
	localparam int NR_W       = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PIXEL_BYTES = 2'd0,
		CFG_ROW_BYTES   = 2'd1,
		CFG_IMAGE_ROWS  = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		FILT_NONE  = 3'd0,
		FILT_SUB   = 3'd1,
		FILT_UP    = 3'd2,
		FILT_AVG   = 3'd3,
		FILT_PAETH = 3'd4
	} filt_t;

	localparam logic [BYTE_W-1:0] FILT_MAX = 8'd4;

	typedef enum logic [1:0] {
		BEAT_DATA,
		BEAT_ROWSTART,
		BEAT_BAD
	} beat_kind_t;

	function automatic logic [BYTE_W-1:0] paeth_pred(
		input logic [BYTE_W-1:0] a,
		input logic [BYTE_W-1:0] b,
		input logic [BYTE_W-1:0] c
	);
		logic [BYTE_W:0]   da;
		logic [BYTE_W:0]   db;
		logic [BYTE_W+1:0] sab;
		logic [BYTE_W+1:0] scc;
		logic [BYTE_W+1:0] dc;
		da  = (b > c) ? ({1'b0, b} - {1'b0, c}) : ({1'b0, c} - {1'b0, b});
		db  = (a > c) ? ({1'b0, a} - {1'b0, c}) : ({1'b0, c} - {1'b0, a});
		sab = {2'b00, a} + {2'b00, b};
		scc = {1'b0, c, 1'b0};
		dc  = (sab > scc) ? (sab - scc) : (scc - sab);
		if ({1'b0, da} <= {1'b0, db} && {1'b0, da} <= dc)
			return a;
		else if ({1'b0, db} <= dc)
			return b;
		else
			return c;
	endfunction

endpackage

[rtl/core/pnguf_if.sv]
// ----------------------------------------------------------------------------
// pnguf stream interfaces
// Valid/ready channels for the filtered byte stream and the rebuilt pixels.
// ----------------------------------------------------------------------------
interface pnguf_in_if;
	logic                          valid;
	logic                          ready;
	logic [pnguf_pkg::BYTE_W-1:0]  stream_byte;

	modport source (output valid, output stream_byte, input ready);
	modport sink   (input valid, input stream_byte, output ready);
endinterface

interface pnguf_out_if;
	logic                          valid;
	logic                          ready;
	logic [pnguf_pkg::BYTE_W-1:0]  pixel_value;
	logic                          row_end;
	logic                          image_end;
	logic                          bad_filter;

	modport source (output valid, output pixel_value, output row_end, output image_end,
		output bad_filter, input ready);
	modport sink   (input valid, input pixel_value, input row_end, input image_end,
		input bad_filter, output ready);
endinterface

[rtl/core/png_scanline_unfilter.sv]
// A data byte is registered in stage 1, then its beat in the output register.
// Throughput: one stream byte per cycle unless the pixel sink stalls; the
// filter byte of a row gives no beat. The left/up-left dependency closes in
// stage 1 next to the line store read port. Reset clears the row/column
// counters, context bytes and halt flag; the line store is not cleared (row 0
// never uses it). An unknown filter type halts the block until the next reset.
// ----------------------------------------------------------------------------
// png_scanline_unfilter
// Rebuilds PNG scanlines (None/Sub/Up/Average/Paeth) from the inflated stream.
// ----------------------------------------------------------------------------
module png_scanline_unfilter (
	input  logic                           clk,
	input  logic                           arst_n,
	pnguf_in_if.sink                       stream,
	pnguf_out_if.source                    pixels,
	input  logic                           cfg_wr_en,
	input  logic [pnguf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pnguf_pkg::CFG_DATA_W-1:0] cfg_data
);
	import pnguf_pkg::*;

	// configuration
	logic [PB_W-1:0] pixel_stride_q;
	logic [RB_W-1:0] row_bytes_q;
	logic [NR_W-1:0] image_rows_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_stride_q <= PB_W'(MAX_PIXEL_BYTES);
			row_bytes_q    <= RB_W'(MAX_ROW_BYTES);
			image_rows_q   <= NR_W'(1);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_PIXEL_BYTES: pixel_stride_q <= cfg_data[PB_W-1:0];
				CFG_ROW_BYTES:   row_bytes_q    <= cfg_data[RB_W-1:0];
				CFG_IMAGE_ROWS:  image_rows_q   <= cfg_data[NR_W-1:0];
				default: ;
			endcase
		end
	end

	logic [SEL_W-1:0] ctx_sel;
	logic [COL_W-1:0] rb_eff;
	logic [NR_W-1:0]  nr_eff;

	always_comb begin
		logic [PB_W-1:0] pb;
		if (pixel_stride_q == '0)
			pb = PB_W'(1);
		else if (pixel_stride_q > PB_W'(MAX_PIXEL_BYTES))
			pb = PB_W'(MAX_PIXEL_BYTES);
		else
			pb = pixel_stride_q;
		ctx_sel = SEL_W'(pb - PB_W'(1));
		if (row_bytes_q == '0)
			rb_eff = COL_W'(1);
		else if ({1'b0, row_bytes_q} > (RB_W+1)'(MAX_ROW_BYTES))
			rb_eff = COL_W'(MAX_ROW_BYTES);
		else
			rb_eff = COL_W'(row_bytes_q);
		nr_eff = (image_rows_q == '0) ? NR_W'(1) : image_rows_q;
	end

	// stage 0: counters and line store read
	logic [COL_W-1:0] col_q;
	logic [NR_W-1:0]  row_q;
	filt_t            row_filter_q;
	logic             halted_q;

	logic             valid_s1;
	beat_kind_t       kind_s1;
	logic [BYTE_W-1:0] byte_s1;
	filt_t            filt_s1;
	logic             first_row_s1;
	logic             last_col_s1;
	logic             last_row_s1;
	logic [ADDR_W-1:0] addr_s1;

	logic             out_valid_q;
	logic             s1_emits;
	logic             s1_go;
	logic             take;
	logic             last_col;
	logic             last_row;
	logic [ADDR_W-1:0] rd_addr;

	assign s1_emits     = (kind_s1 != BEAT_ROWSTART);
	assign s1_go        = valid_s1 && (!s1_emits || !out_valid_q || pixels.ready);
	assign stream.ready = !valid_s1 || s1_go;
	assign take         = stream.valid && stream.ready && !halted_q;

	assign rd_addr  = ADDR_W'(col_q - COL_W'(1));
	assign last_col = (col_q >= rb_eff);
	assign last_row = last_col && (({1'b0, row_q} + (NR_W+1)'(1)) >= {1'b0, nr_eff});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			row_q        <= '0;
			row_filter_q <= FILT_NONE;
			halted_q     <= 1'b0;
		end else if (take) begin
			if (col_q == '0) begin
				if (stream.stream_byte > FILT_MAX) begin
					halted_q <= 1'b1;
				end else begin
					row_filter_q <= filt_t'(stream.stream_byte[2:0]);
					col_q        <= COL_W'(1);
				end
			end else if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + NR_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (take)
			valid_s1 <= 1'b1;
		else if (s1_go)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1      <= stream.stream_byte;
			filt_s1      <= row_filter_q;
			first_row_s1 <= (row_q == '0);
			last_col_s1  <= last_col;
			last_row_s1  <= last_row;
			addr_s1      <= rd_addr;
			if (col_q != '0)
				kind_s1 <= BEAT_DATA;
			else if (stream.stream_byte > FILT_MAX)
				kind_s1 <= BEAT_BAD;
			else
				kind_s1 <= BEAT_ROWSTART;
		end
	end

	// stage 1: predictor, context shift, write back
	logic [BYTE_W-1:0] ram_rdata;
	logic [BYTE_W-1:0] left_q   [MAX_PIXEL_BYTES];
	logic [BYTE_W-1:0] upleft_q [MAX_PIXEL_BYTES];
	logic [BYTE_W-1:0] a_val;
	logic [BYTE_W-1:0] b_val;
	logic [BYTE_W-1:0] c_val;
	logic [BYTE_W-1:0] pred;
	logic [BYTE_W-1:0] pix;
	logic [BYTE_W:0]   avg_sum;

	pnguf_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(MAX_ROW_BYTES)
	) u_prior_row (
		.clk  (clk),
		.we   (s1_go && kind_s1 == BEAT_DATA),
		.waddr(addr_s1),
		.wdata(pix),
		.re   (take && col_q != '0),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	assign a_val   = left_q[ctx_sel];
	assign c_val   = upleft_q[ctx_sel];
	assign b_val   = first_row_s1 ? '0 : ram_rdata;
	assign avg_sum = {1'b0, a_val} + {1'b0, b_val};

	always_comb begin
		unique case (filt_s1)
			FILT_NONE:  pred = '0;
			FILT_SUB:   pred = a_val;
			FILT_UP:    pred = b_val;
			FILT_AVG:   pred = avg_sum[BYTE_W:1];
			FILT_PAETH: pred = paeth_pred(a_val, b_val, c_val);
			default:    pred = '0;
		endcase
		pix = byte_s1 + pred;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
				left_q[i]   <= '0;
				upleft_q[i] <= '0;
			end
		end else if (s1_go) begin
			if (kind_s1 == BEAT_DATA) begin
				for (int i = MAX_PIXEL_BYTES - 1; i > 0; i--) begin
					left_q[i]   <= left_q[i-1];
					upleft_q[i] <= upleft_q[i-1];
				end
				left_q[0]   <= pix;
				upleft_q[0] <= b_val;
			end else begin
				// new row: left and up-left neighbors are outside the image
				for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
					left_q[i]   <= '0;
					upleft_q[i] <= '0;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (s1_go && s1_emits)
			out_valid_q <= 1'b1;
		else if (pixels.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s1_go && s1_emits) begin
			if (kind_s1 == BEAT_BAD) begin
				pixels.pixel_value <= '0;
				pixels.row_end     <= 1'b0;
				pixels.image_end   <= 1'b0;
				pixels.bad_filter  <= 1'b1;
			end else begin
				pixels.pixel_value <= pix;
				pixels.row_end     <= last_col_s1;
				pixels.image_end   <= last_row_s1;
				pixels.bad_filter  <= 1'b0;
			end
		end
	end

	assign pixels.valid = out_valid_q;

endmodule

[rtl/core/pnguf_ram.sv]
// ----------------------------------------------------------------------------
// pnguf_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module pnguf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule

[rtl/core/pnguf_checker.sv]
// ----------------------------------------------------------------------------
// pnguf_checker
// Port-level checks on the pixel beats of the scanline unfilter.
// ----------------------------------------------------------------------------
module pnguf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] pixel_value,
	input logic       row_end,
	input logic       image_end,
	input logic       bad_filter
);

	logic seen_bad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			seen_bad_q <= 1'b0;
		else if (out_valid && out_ready && bad_filter)
			seen_bad_q <= 1'b1;
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid &&
			$stable({pixel_value, row_end, image_end, bad_filter}))
		else $error("pixel beat changed while stalled");

	a_bad_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_filter |-> pixel_value == 8'd0 && !row_end && !image_end)
		else $error("bad filter beat carries data");

	a_image_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && image_end |-> row_end)
		else $error("image end without row end");

	a_halt: assert property (@(posedge clk) disable iff (!arst_n)
		seen_bad_q |-> !out_valid)
		else $error("beat after bad filter");

endmodule

bind png_scanline_unfilter pnguf_checker u_pnguf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (pixels.valid),
	.out_ready  (pixels.ready),
	.pixel_value(pixels.pixel_value),
	.row_end    (pixels.row_end),
	.image_end  (pixels.image_end),
	.bad_filter (pixels.bad_filter)
);

[tb/sv/tb_png_scanline_unfilter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_png_scanline_unfilter
// Self-checking bench for the PNG scanline unfilter. A scoreboard class mirrors
// the line store, left context and row/column counters, predicts each pixel
// beat from the accepted stream bytes and compares the beats that come out.
// Stimulus: directed rows for every filter and the register corner cases,
// random images with mid-image register changes, one image under a long sink
// stall, then an unknown filter type followed by bytes the halted block must drop.
// ----------------------------------------------------------------------------
module tb_png_scanline_unfilter;
	import pnguf_pkg::*;

	localparam int SETTLE_CYCLES   = 4;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int SMALL_ITEMS     = 820;

	typedef struct packed {
		logic [BYTE_W-1:0] pixel_value;
		logic              row_end;
		logic              image_end;
		logic              bad_filter;
	} pixel_beat_t;

	class pixel_scoreboard;
		logic [BYTE_W-1:0] line_store [MAX_ROW_BYTES];
		logic [BYTE_W-1:0] left_bytes [MAX_PIXEL_BYTES];
		logic [BYTE_W-1:0] upleft_bytes [MAX_PIXEL_BYTES];
		filt_t             filter;
		int unsigned       col;
		int unsigned       row;
		bit                halted;
		logic [PB_W-1:0]   pixel_stride_reg;
		logic [RB_W-1:0]   row_bytes_reg;
		logic [NR_W-1:0]   image_rows_reg;
		pixel_beat_t       expected_pixels[$];
		int unsigned       mismatches;

		function new();
			pixel_stride_reg = PB_W'(4);
			row_bytes_reg    = RB_W'(MAX_ROW_BYTES);
			image_rows_reg   = NR_W'(1);
			clear_context();
			filter     = FILT_NONE;
			col        = 0;
			row        = 0;
			halted     = 1'b0;
			mismatches = 0;
		endfunction

		function void clear_context();
			for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
				left_bytes[i]   = '0;
				upleft_bytes[i] = '0;
			end
		endfunction

		function void write_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				CFG_PIXEL_BYTES: pixel_stride_reg = value[PB_W-1:0];
				CFG_ROW_BYTES:   row_bytes_reg    = value[RB_W-1:0];
				CFG_IMAGE_ROWS:  image_rows_reg   = value[NR_W-1:0];
				default: ;
			endcase
		endfunction

		// zero acts as one, oversize values saturate
		function int unsigned pixel_stride();
			if (pixel_stride_reg == 0)
				return 1;
			return (pixel_stride_reg > MAX_PIXEL_BYTES) ? MAX_PIXEL_BYTES : pixel_stride_reg;
		endfunction

		function int unsigned bytes_per_row();
			if (row_bytes_reg == 0)
				return 1;
			return (row_bytes_reg > MAX_ROW_BYTES) ? MAX_ROW_BYTES : row_bytes_reg;
		endfunction

		function int unsigned rows_per_image();
			return (image_rows_reg == 0) ? 1 : image_rows_reg;
		endfunction

		function logic [BYTE_W-1:0] paeth_select(logic [BYTE_W-1:0] a, logic [BYTE_W-1:0] b,
			logic [BYTE_W-1:0] c);
			int ia, ib, ic, p, da, db, dc;
			ia = a;
			ib = b;
			ic = c;
			p  = ia + ib - ic;
			da = (p >= ia) ? p - ia : ia - p;
			db = (p >= ib) ? p - ib : ib - p;
			dc = (p >= ic) ? p - ic : ic - p;
			if (da <= db && da <= dc)
				return a;
			if (db <= dc)
				return b;
			return c;
		endfunction

		function void note_stream_byte(logic [BYTE_W-1:0] x);
			int unsigned       d;
			logic [BYTE_W-1:0] a, b, c, guess, v;
			bit                last_col, last_row;
			pixel_beat_t       beat;
			if (halted)
				return;
			if (col == 0) begin
				clear_context();
				if (x > FILT_MAX) begin
					halted           = 1'b1;
					beat             = '0;
					beat.bad_filter  = 1'b1;
					expected_pixels.push_back(beat);
					return;
				end
				filter = filt_t'(x[2:0]);
				col    = 1;
				return;
			end
			d = col - 1;
			if (d >= MAX_ROW_BYTES)
				d = MAX_ROW_BYTES - 1;
			a = left_bytes[pixel_stride() - 1];
			c = upleft_bytes[pixel_stride() - 1];
			b = (row == 0) ? '0 : line_store[d];
			case (filter)
				FILT_SUB:   guess = a;
				FILT_UP:    guess = b;
				FILT_AVG:   guess = BYTE_W'((int'(a) + int'(b)) / 2);
				FILT_PAETH: guess = paeth_select(a, b, c);
				default:    guess = '0;
			endcase
			v = x + guess;
			for (int i = MAX_PIXEL_BYTES - 1; i > 0; i--) begin
				left_bytes[i]   = left_bytes[i - 1];
				upleft_bytes[i] = upleft_bytes[i - 1];
			end
			left_bytes[0]   = v;
			upleft_bytes[0] = b;
			line_store[d]   = v;
			last_col = (col >= bytes_per_row());
			last_row = last_col && (row + 1 >= rows_per_image());
			if (last_col) begin
				col = 0;
				row = last_row ? 0 : ((row + 1) & 32'hFFFF);
			end else begin
				col++;
			end
			beat.pixel_value = v;
			beat.row_end     = last_col;
			beat.image_end   = last_row;
			beat.bad_filter  = 1'b0;
			expected_pixels.push_back(beat);
		endfunction

		task report_mismatch(string what);
			if (mismatches < 40)
				$display("%0t mismatch: %s", $time, what);
			mismatches++;
		endtask

		task check_pixel(pixel_beat_t got);
			pixel_beat_t want;
			if (expected_pixels.size() == 0) begin
				report_mismatch($sformatf("unexpected beat %p", got));
				return;
			end
			want = expected_pixels.pop_front();
			if (got.pixel_value !== want.pixel_value)
				report_mismatch($sformatf("pixel_value %02h, want %02h",
					got.pixel_value, want.pixel_value));
			if (got.row_end !== want.row_end)
				report_mismatch($sformatf("row_end %b, want %b", got.row_end, want.row_end));
			if (got.image_end !== want.image_end)
				report_mismatch($sformatf("image_end %b, want %b",
					got.image_end, want.image_end));
			if (got.bad_filter !== want.bad_filter)
				report_mismatch($sformatf("bad_filter %b, want %b",
					got.bad_filter, want.bad_filter));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	pnguf_in_if  byte_ch();
	pnguf_out_if pixel_ch();

	png_scanline_unfilter u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.stream    (byte_ch),
		.pixels    (pixel_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	pixel_scoreboard   sb = new();
	logic [BYTE_W-1:0] tx_bytes[$];
	bit                hold_off_request = 1'b0;

	always #4 clk = ~clk;

	always @(posedge clk) begin
		pixel_beat_t got;
		if (arst_n) begin
			if (byte_ch.valid && byte_ch.ready)
				sb.note_stream_byte(byte_ch.stream_byte);
			if (pixel_ch.valid && pixel_ch.ready) begin
				got.pixel_value = pixel_ch.pixel_value;
				got.row_end     = pixel_ch.row_end;
				got.image_end   = pixel_ch.image_end;
				got.bad_filter  = pixel_ch.bad_filter;
				sb.check_pixel(got);
			end
		end
	end

	// pixel sink: stall modes that change at random intervals, plus a long
	// hold-off on request so the pipeline backs up into the stream input
	initial begin
		int unsigned mode;
		int unsigned mode_left;
		int unsigned hold_left;
		pixel_ch.ready <= 1'b0;
		mode      = 0;
		mode_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_off_request) begin
				hold_off_request = 1'b0;
				hold_left        = HOLD_OFF_CYCLES;
			end
			if (mode_left == 0) begin
				mode      = $urandom_range(0, 3);
				mode_left = $urandom_range(16, 200);
			end
			mode_left--;
			if (hold_left != 0) begin
				hold_left--;
				pixel_ch.ready <= 1'b0;
			end else begin
				case (mode)
					0:       pixel_ch.ready <= 1'b1;
					1:       pixel_ch.ready <= ($urandom_range(0, 3) != 0);
					2:       pixel_ch.ready <= ($urandom_range(0, 3) == 0);
					default: pixel_ch.ready <= ~pixel_ch.ready;
				endcase
			end
		end
	end

	initial begin
		#10_000_000;
		$display("status: fail");
		$finish;
	end

	function automatic logic [BYTE_W-1:0] filter_byte(filt_t f);
		return {5'd0, f};
	endfunction

	// data bytes lean on a few corner values so Paeth ties and carries show up
	function automatic logic [BYTE_W-1:0] pick_data();
		case ($urandom_range(0, 5))
			0:       return 8'h00;
			1:       return 8'hFF;
			2:       return BYTE_W'($urandom_range(126, 129));
			default: return BYTE_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic int unsigned random_setting(cfg_reg_t idx);
		case (idx)
			CFG_PIXEL_BYTES:
				return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
			CFG_ROW_BYTES:
				if ($urandom_range(0, 15) == 0)
					return 0;
				else
					return ($urandom_range(0, 3) == 0) ? $urandom_range(13, 40)
						: $urandom_range(1, 12);
			default:
				return ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 5);
		endcase
	endfunction

	// queue well-formed bytes from the current stream position; stops after
	// max_bytes or on the last byte of the image, whichever comes first
	function automatic int unsigned queue_stream(int unsigned max_bytes);
		int unsigned col, row, n;
		col = sb.col;
		row = sb.row;
		n   = 0;
		while (n < max_bytes) begin
			n++;
			if (col == 0) begin
				tx_bytes.push_back(BYTE_W'($urandom_range(0, FILT_MAX)));
				col = 1;
			end else begin
				tx_bytes.push_back(pick_data());
				if (col >= sb.bytes_per_row()) begin
					col = 0;
					if (row + 1 >= sb.rows_per_image())
						break;
					row++;
				end else begin
					col++;
				end
			end
		end
		return n;
	endfunction

	task automatic send_queued();
		int unsigned burst_left;
		int unsigned gap;
		while (tx_bytes.size() != 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
				: $urandom_range(1, 24);
			byte_ch.valid       <= 1'b1;
			byte_ch.stream_byte <= tx_bytes[0];
			while (burst_left != 0) begin
				@(posedge clk);
				if (byte_ch.ready) begin
					void'(tx_bytes.pop_front());
					burst_left--;
					if (tx_bytes.size() == 0)
						burst_left = 0;
					else if (burst_left != 0)
						byte_ch.stream_byte <= tx_bytes[0];
				end
			end
			// a zero gap keeps valid high straight into the next burst
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (tx_bytes.size() == 0 || gap != 0) begin
				byte_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// filter bytes give no beat, so let the block settle after the
	// last expected beat before touching the registers
	task automatic stream_and_settle();
		send_queued();
		@(posedge clk);
		while (sb.expected_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(cfg_reg_t idx, int unsigned value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(value);
		@(posedge clk);
		sb.write_register(idx, CFG_DATA_W'(value));
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int unsigned small_items;
		int unsigned cut;
		int unsigned setting;
		bit          hold_done;
		cfg_reg_t    pick;

		arst_n              <= 1'b0;
		byte_ch.valid       <= 1'b0;
		byte_ch.stream_byte <= '0;
		cfg_wr_en           <= 1'b0;
		cfg_index           <= CFG_PIXEL_BYTES;
		cfg_data            <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, Paeth on the first row, then row_bytes cut below the
		// current column so the row and image end on the next byte
		tx_bytes = '{filter_byte(FILT_PAETH), 8'hFF, 8'h00, 8'h80, 8'h7F, 8'h01};
		stream_and_settle();
		write_register(CFG_ROW_BYTES, 3);
		tx_bytes = '{8'hAA};
		stream_and_settle();

		// one filter per row; pixel stride zero acts as one; image_rows at max
		// then dropped to zero mid-image ends the image at the next row end
		write_register(CFG_PIXEL_BYTES, 0);
		write_register(CFG_ROW_BYTES, 2);
		write_register(CFG_IMAGE_ROWS, 65535);
		tx_bytes = '{filter_byte(FILT_NONE), 8'hFF, 8'h01,
			filter_byte(FILT_SUB), 8'hFF, 8'h02,
			filter_byte(FILT_UP), 8'hFF, 8'h80,
			filter_byte(FILT_AVG), 8'h01, 8'hFF};
		stream_and_settle();
		write_register(CFG_IMAGE_ROWS, 0);
		write_register(CFG_PIXEL_BYTES, 2);
		tx_bytes = '{filter_byte(FILT_PAETH), 8'h7F, 8'h80};
		stream_and_settle();

		// oversize pixel stride, zero row_bytes: one-byte single-row images
		write_register(CFG_PIXEL_BYTES, 7);
		write_register(CFG_ROW_BYTES, 0);
		tx_bytes = '{filter_byte(FILT_AVG), 8'hC3, filter_byte(FILT_PAETH), 8'h3C};
		stream_and_settle();

		small_items = 0;
		hold_done   = 1'b0;
		while (small_items < SMALL_ITEMS) begin
			write_register(CFG_PIXEL_BYTES, random_setting(CFG_PIXEL_BYTES));
			write_register(CFG_ROW_BYTES, random_setting(CFG_ROW_BYTES));
			write_register(CFG_IMAGE_ROWS, random_setting(CFG_IMAGE_ROWS));
			if (!hold_done && small_items >= SMALL_ITEMS / 2) begin
				// multi-row image under a long sink stall backs up the input
				hold_done = 1'b1;
				write_register(CFG_ROW_BYTES, 12);
				write_register(CFG_IMAGE_ROWS, 3);
				hold_off_request = 1'b1;
			end
			if ($urandom_range(0, 3) == 0) begin
				// break the image, change one register, carry on
				cut = $urandom_range(1, 30);
				small_items += queue_stream(cut);
				stream_and_settle();
				pick    = cfg_reg_t'($urandom_range(0, 2));
				setting = random_setting(pick);
				// a longer row past row 0 would read above bytes never written
				if (pick == CFG_ROW_BYTES && sb.row != 0 && setting > sb.bytes_per_row())
					setting = sb.bytes_per_row();
				write_register(pick, setting);
			end
			small_items += queue_stream(32'hFFFF_FFFF);
			stream_and_settle();
		end

		// unknown filter type halts the block; the rest must be dropped
		tx_bytes.push_back(BYTE_W'($urandom_range(FILT_MAX + 1, 255)));
		repeat (20) tx_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
		stream_and_settle();
		repeat (8) @(posedge clk);

		if (sb.expected_pixels.size() != 0)
			sb.report_mismatch($sformatf("%0d expected beats never came",
				sb.expected_pixels.size()));
		if (sb.mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
